### rtl/core/rfms_pkg.sv
`default_nettype none
package rfms_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANGULAR_RATE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION_AXIS = 2'd2;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;
endpackage
`default_nettype wire

### rtl/core/rfms_if.sv
`default_nettype none
interface rfms_in_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic [W-2:0] density;
  logic signed [W-1:0] momentum_x, momentum_y, momentum_z;
  logic signed [W-1:0] radius_x, radius_y, radius_z;
  logic cell_covered;
  modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                  radius_x, radius_y, radius_z, cell_covered, input ready);
  modport sink (input valid, density, momentum_x, momentum_y, momentum_z,
                radius_x, radius_y, radius_z, cell_covered, output ready);
endinterface

interface rfms_out_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] force_x, force_y, force_z;
  logic saturated;
  modport source (output valid, force_x, force_y, force_z, saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface
`default_nettype wire

### rtl/core/rotating_frame_momentum_source_core.sv
// channel   dir  payload
// cell_in   in   density, momentum_x/y/z, radius_x/y/z, cell_covered
// force_out out  force_x/y/z, saturated
// cfg       in   cfg_we, cfg_index, cfg_data
// One word per cycle while the output is not stalled; six register stages: w*w,
// coriolis products, rho*w2, rounding and doubling, centrifugal products, then
// the sums into the output register.
// The whole pipeline advances when the output stage is empty or taken, so a
// stall freezes every stage and nothing is lost or repeated.
// Synchronous reset clears valid bits, frame enable and angular rate, and selects the Z axis.
`default_nettype none
module rotating_frame_momentum_source_core
  import rfms_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [WORD_BITS-1:0] cfg_data,
  rfms_in_if.sink   cell_in,
  rfms_out_if.source force_out
);
  localparam int W = WORD_BITS;
  localparam int NS = 6;
  typedef logic signed [W-1:0] word_t;
  typedef struct packed {
    logic sat;
    logic signed [W-1:0] val;
  } sres_t;

  localparam word_t MAXV = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(W-1){1'b0}}};

  // round half away from zero of a signed product, shift, saturate
  function automatic sres_t fround(input logic signed [2*W-1:0] p);
    logic neg;
    logic [2*W-1:0] mg, q;
    sres_t r;
    neg = p[2*W-1];
    mg = neg ? (~p + 1'b1) : p;
    q = (mg + ({{(2*W-1){1'b0}}, 1'b1} << (FRAC_BITS-1))) >> FRAC_BITS;
    r.sat = 1'b0;
    if (neg) begin
      if (q > {{W{1'b0}}, 1'b1, {(W-1){1'b0}}}) begin
        r.sat = 1'b1; r.val = MINV;
      end else r.val = word_t'(~q[W-1:0] + 1'b1);
    end else begin
      if (q > {{(W+1){1'b0}}, {(W-1){1'b1}}}) begin
        r.sat = 1'b1; r.val = MAXV;
      end else r.val = word_t'(q[W-1:0]);
    end
    return r;
  endfunction

  function automatic sres_t sadd(input word_t a, input word_t b);
    logic signed [W:0] s;
    sres_t r;
    s = {a[W-1], a} + {b[W-1], b};
    r.sat = 1'b0;
    r.val = s[W-1:0];
    if (s > $signed({2'b00, {(W-1){1'b1}}})) begin
      r.sat = 1'b1; r.val = MAXV;
    end else if (s < $signed({2'b11, {(W-1){1'b0}}})) begin
      r.sat = 1'b1; r.val = MINV;
    end
    return r;
  endfunction

  logic frame_enable;
  word_t angular_rate;
  logic [1:0] rotation_axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_enable <= 1'b0;
      angular_rate <= '0;
      rotation_axis <= AXIS_Z;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ENABLE:  frame_enable <= cfg_data[0];
        REG_ANGULAR_RATE:  angular_rate <= word_t'(cfg_data);
        REG_ROTATION_AXIS: rotation_axis <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic adv;
  assign adv = !vld[NS-1] || force_out.ready;
  assign cell_in.ready = adv;
  assign force_out.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], cell_in.valid};
  end

  // stage 1: pick b/c components, w*w product
  logic zero1, zero2, zero3, zero4, zero5;
  logic [1:0] ax1, ax2, ax3, ax4, ax5;
  logic [W-2:0] rho1;
  word_t mb1, mc1, rb1, rc1;
  logic signed [2*W-1:0] ww1;
  word_t mb_s, mc_s, rb_s, rc_s;

  always_comb begin
    case (rotation_axis)
      AXIS_X: begin
        mb_s = cell_in.momentum_y; mc_s = cell_in.momentum_z;
        rb_s = cell_in.radius_y;   rc_s = cell_in.radius_z;
      end
      AXIS_Y: begin
        mb_s = cell_in.momentum_z; mc_s = cell_in.momentum_x;
        rb_s = cell_in.radius_z;   rc_s = cell_in.radius_x;
      end
      default: begin
        mb_s = cell_in.momentum_x; mc_s = cell_in.momentum_y;
        rb_s = cell_in.radius_x;   rc_s = cell_in.radius_y;
      end
    endcase
  end

  // stage 2: round w2, coriolis products
  sres_t w2_2;
  logic signed [2*W-1:0] pb2, pc2;
  logic [W-2:0] rho2;
  word_t rb2, rc2;
  // stage 3: rho*w2 product, round coriolis
  logic signed [2*W-1:0] rw3;
  sres_t cb3, cc3;
  logic sat3;
  word_t rb3, rc3;
  // stage 4: round rho*w2, double both coriolis terms, negate the c term
  sres_t rw4, cb4, cc4;
  logic sat4;
  word_t rb4, rc4;
  // stage 5: centrifugal products
  logic signed [2*W-1:0] qb5, qc5;
  word_t cb5, cc5;
  logic sat5;

  sres_t cb_d, cc_d, cc_n, rwr, pbr, pcr, fb, fc, qbr, qcr;
  always_comb begin
    rwr = fround(rw3);
    cb_d = sadd(cb3.val, cb3.val);
    cc_d = sadd(cc3.val, cc3.val);
    cc_n.sat = cc_d.sat || (cc_d.val == MINV);
    cc_n.val = (cc_d.val == MINV) ? MAXV : -cc_d.val;
    pbr = fround(pb2);
    pcr = fround(pc2);
    qbr = fround(qb5);
    qcr = fround(qc5);
    fb = sadd(cb5, qbr.val);
    fc = sadd(cc5, qcr.val);
  end

  word_t f_x, f_y, f_z;
  logic sat_o;

  always_ff @(posedge clk) begin
    if (adv) begin
      zero1 <= cell_in.cell_covered || !frame_enable || rotation_axis == AXIS_NONE;
      ax1 <= rotation_axis;
      rho1 <= cell_in.density;
      mb1 <= mb_s; mc1 <= mc_s; rb1 <= rb_s; rc1 <= rc_s;
      ww1 <= angular_rate * angular_rate;

      zero2 <= zero1; ax2 <= ax1;
      w2_2 <= fround(ww1);
      pb2 <= angular_rate * mc1;
      pc2 <= angular_rate * mb1;
      rho2 <= rho1; rb2 <= rb1; rc2 <= rc1;

      zero3 <= zero2; ax3 <= ax2;
      rw3 <= $signed({1'b0, rho2}) * w2_2.val;
      sat3 <= w2_2.sat;
      cb3 <= pbr; cc3 <= pcr;
      rb3 <= rb2; rc3 <= rc2;

      zero4 <= zero3; ax4 <= ax3;
      rw4 <= rwr;
      cb4 <= cb_d; cc4 <= cc_n;
      sat4 <= sat3 || cb3.sat || cc3.sat;
      rb4 <= rb3; rc4 <= rc3;

      zero5 <= zero4; ax5 <= ax4;
      qb5 <= rw4.val * rb4;
      qc5 <= rw4.val * rc4;
      cb5 <= cb4.val; cc5 <= cc4.val;
      sat5 <= sat4 || rw4.sat || cb4.sat || cc4.sat;

      f_x <= '0; f_y <= '0; f_z <= '0;
      sat_o <= 1'b0;
      if (!zero5) begin
        sat_o <= sat5 || qbr.sat || qcr.sat || fb.sat || fc.sat;
        case (ax5)
          AXIS_X: begin f_y <= fb.val; f_z <= fc.val; end
          AXIS_Y: begin f_z <= fb.val; f_x <= fc.val; end
          default: begin f_x <= fb.val; f_y <= fc.val; end
        endcase
      end
    end
  end

  assign force_out.force_x = f_x;
  assign force_out.force_y = f_y;
  assign force_out.force_z = f_z;
  assign force_out.saturated = sat_o;
endmodule
`default_nettype wire
